// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define ASSERT_CLKD(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: sv/cdes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cdes_pkg;

  localparam int DayW    = 5;
  localparam int MonW    = 4;
  localparam int YearW   = 12;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int EpochW  = 33;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  localparam int YearDaysW = 21;
  localparam int LeapCntW  = 11;
  localparam int MonDaysW  = 9;
  localparam int TodW      = 17;

  // n / 100 as (n * 5243) >> 19, exact for n below 4096
  localparam int RecipW     = 13;
  localparam int RecipProdW = YearW + RecipW;
  localparam int RecipShift = 19;
  localparam int QuotW      = RecipProdW - RecipShift;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonMar = 4'd3;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  // 365 * 1970 + leap years before 1970 (478) + 1 for the one-based day
  localparam logic [EpochW-1:0] DayBias    = 33'd719529;
  localparam logic [TodW-1:0]   SecsPerDay = 17'd86400;

  typedef struct packed {
    logic [YearDaysW-1:0] year_days;
    logic [LeapCntW-1:0]  leap_count;
    logic [MonDaysW-1:0]  month_days;
    logic                 leap_day;
    logic [DayW-1:0]      day;
    logic [TodW-1:0]      tod;
  } cdes_cal_t;

  typedef struct packed {
    logic [EpochW-1:0] days;
    logic [TodW-1:0]   tod;
  } cdes_days_t;

  function automatic logic [MonDaysW-1:0] days_before_month(input logic [MonW-1:0] m);
    logic [MonDaysW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/cdes_year_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cdes_year_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [cdes_pkg::InDataW-1:0] in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output cdes_pkg::cdes_cal_t            out_data
);
  import cdes_pkg::*;

  logic [DayW-1:0]  day;
  logic [MonW-1:0]  month;
  logic [YearW-1:0] year;
  logic [HourW-1:0] hour;
  logic [MinW-1:0]  minute;
  logic [SecW-1:0]  second;

  assign day    = in_data[4:0];
  assign month  = in_data[8:5];
  assign year   = in_data[20:9];
  assign hour   = in_data[25:21];
  assign minute = in_data[31:26];
  assign second = in_data[37:32];

  // stage 1: reciprocal products, year days, month table, time of day
  logic                  v1_r;
  logic [RecipProdW-1:0] prod_n_r, prod_n_nxt;
  logic [RecipProdW-1:0] prod_y_r, prod_y_nxt;
  logic [YearDaysW-1:0]  ydays1_r, ydays1_nxt;
  logic [MonDaysW-1:0]   mdays1_r, mdays1_nxt;
  logic                  past_feb_r, past_feb_nxt;
  logic                  yzero_r, yzero_nxt;
  logic [YearW-1:0]      year1_r;
  logic [DayW-1:0]       day1_r;
  logic [TodW-1:0]       tod1_r, tod1_nxt;
  logic                  adv1, adv2;

  logic v2_r;
  cdes_cal_t cal_r, cal_nxt;

  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    prod_n_nxt   = RecipProdW'(year - 12'd1) * RecipProdW'(Recip100);
    prod_y_nxt   = RecipProdW'(year) * RecipProdW'(Recip100);
    ydays1_nxt   = YearDaysW'(year) * YearDaysW'(365);
    mdays1_nxt   = days_before_month(month);
    past_feb_nxt = (month >= MonMar) && (month <= MonDec);
    yzero_nxt    = (year == '0);
    tod1_nxt     = TodW'(hour) * TodW'(3600) + TodW'(minute) * TodW'(60) + TodW'(second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      prod_n_r   <= prod_n_nxt;
      prod_y_r   <= prod_y_nxt;
      ydays1_r   <= ydays1_nxt;
      mdays1_r   <= mdays1_nxt;
      past_feb_r <= past_feb_nxt;
      yzero_r    <= yzero_nxt;
      year1_r    <= year;
      day1_r     <= day;
      tod1_r     <= tod1_nxt;
    end
  end

  // stage 2: leap years before the given year and the leap flag
  logic [QuotW-1:0] q_n, q_y;
  logic [YearW-1:0] n1;
  logic             div100, is_leap;

  always_comb begin
    q_n    = prod_n_r[RecipProdW-1:RecipShift];
    q_y    = prod_y_r[RecipProdW-1:RecipShift];
    n1     = year1_r - 12'd1;
    div100 = (year1_r == YearW'(q_y) * YearW'(100));
    is_leap = (year1_r[1:0] == 2'b00) && (!div100 || (q_y[1:0] == 2'b00));

    cal_nxt.year_days  = ydays1_r;
    cal_nxt.month_days = mdays1_r;
    cal_nxt.day        = day1_r;
    cal_nxt.tod        = tod1_r;
    cal_nxt.leap_day   = past_feb_r && is_leap;
    // year zero counts itself as leap, so nothing lies below it
    if (yzero_r) begin
      cal_nxt.leap_count = '0;
    end else begin
      cal_nxt.leap_count = LeapCntW'(n1[YearW-1:2]) - LeapCntW'(q_n)
                         + LeapCntW'(q_n[QuotW-1:2]) + LeapCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      cal_r <= cal_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = cal_r;

endmodule

`default_nettype wire

// File: sv/cdes_day_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cdes_day_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cdes_pkg::cdes_cal_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cdes_pkg::cdes_days_t   out_data
);
  import cdes_pkg::*;

  logic       v_r;
  logic       adv;
  cdes_days_t days_r, days_nxt;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  // years before 1970 go negative and wrap in 33 bits
  always_comb begin
    days_nxt.days = EpochW'(in_data.year_days) + EpochW'(in_data.leap_count)
                  + EpochW'(in_data.month_days) + EpochW'(in_data.leap_day)
                  + EpochW'(in_data.day) - DayBias;
    days_nxt.tod  = in_data.tod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      days_r <= days_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = days_r;

endmodule

`default_nettype wire

// File: sv/cdes_scale_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cdes_scale_stage (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire cdes_pkg::cdes_days_t           in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cdes_pkg::EpochW-1:0]         out_secs
);
  import cdes_pkg::*;

  logic              v4_r, v5_r;
  logic              adv4, adv5;
  logic [EpochW-1:0] dsecs_r, dsecs_nxt;
  logic [TodW-1:0]   tod4_r;
  logic [EpochW-1:0] secs_r, secs_nxt;

  assign adv5     = !v5_r || out_ready;
  assign adv4     = !v4_r || adv5;
  assign in_ready = adv4;

  // only the low 33 bits of the product are kept
  assign dsecs_nxt = in_data.days * EpochW'(SecsPerDay);
  assign secs_nxt  = dsecs_r + EpochW'(tod4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv4) begin
        v4_r <= in_valid;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && in_valid) begin
      dsecs_r <= dsecs_nxt;
      tod4_r  <= in_data.tod;
    end
    if (adv5 && v4_r) begin
      secs_r <= secs_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_secs  = secs_r;

endmodule

`default_nettype wire

// File: sv/civil_date_to_epoch_seconds.sv
// Converts a decoded Gregorian date and time into seconds since 1970-01-01 00:00:00,
// wrapped to 33 bits. One transaction is taken every clock cycle unless back-pressure
// stalls the pipe, and each result passes through five register stages: reciprocal
// products and time of day, leap count, day sum, the multiply by 86400 and the final
// add. Every stage holds its own valid bit, so bubbles close up under back-pressure;
// in_tready follows out_tready combinationally through the stages. Months outside
// 1 to 12 add no days, and no leap-second correction is applied.
`timescale 1ns / 1ps
`default_nettype none

module civil_date_to_epoch_seconds (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // day_of_month[4:0], month_number[8:5], year_number[20:9], hour_of_day[25:21],
  // minute_of_hour[31:26], second_of_minute[37:32], zero[39:38]
  input  wire logic [cdes_pkg::InDataW-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // epoch_seconds[32:0], zero[39:33]
  output logic [cdes_pkg::OutDataW-1:0]      out_tdata
);
  import cdes_pkg::*;

  logic       cal_valid, cal_ready;
  cdes_cal_t  cal_data;
  logic       days_valid, days_ready;
  cdes_days_t days_data;
  logic [EpochW-1:0] secs;

  cdes_year_stage u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (cal_valid),
    .out_ready (cal_ready),
    .out_data  (cal_data)
  );

  cdes_day_stage u_day (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cal_valid),
    .in_ready  (cal_ready),
    .in_data   (cal_data),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_data  (days_data)
  );

  cdes_scale_stage u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_data   (days_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_secs  (secs)
  );

  assign out_tdata = {{(OutDataW - EpochW){1'b0}}, secs};

endmodule

`default_nettype wire

// File: sv/cdes_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdes_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [cdes_pkg::InDataW-1:0]  in_tdata,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cdes_pkg::OutDataW-1:0] out_tdata
);
  import cdes_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `ASSERT_CLKD(a_pad_zero, clk, rst_n, out_tvalid |-> (out_tdata[OutDataW-1:EpochW] == '0), "pad bits set")
  `ASSERT_CLKD(a_ready_flow, clk, rst_n, out_tready |-> in_tready, "input stalled while output drains")
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `ASSERT_CLKD(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed under stall")

endmodule

bind civil_date_to_epoch_seconds cdes_checker u_cdes_checker (.*);

`default_nettype wire
